>>> rtl/core/sefd_pkg.sv
// Shared types and constants for the sensor edge interval frame decoder.
package sefd_pkg;

  localparam int unsigned FrameLen    = 40;
  localparam int unsigned PosWidth    = 6;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned SepWidth    = 14;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [CountWidth-1:0] PeriodReset    = 16'd10000;
  localparam logic [SepWidth-1:0]   SeparatorReset = 14'd50;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_EDGE    = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_PKT_ERR   = 2'd1,
    STATUS_NO_CONN   = 2'd2,
    STATUS_CHECK_ERR = 2'd3
  } status_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_TIMER_PERIOD  = 1'd0,
    REG_BIT_SEPARATOR = 1'd1
  } cfg_reg_t;

endpackage

>>> rtl/core/sensor_edge_interval_frame_decoder.sv
// Decodes a 40-bit single-wire sensor frame from falling edge timestamps.
// Each input transaction passes through an input register, then a result register.
// Throughput: one input transaction per cycle; the stage advances whenever the result
// register is empty or being drained in the same cycle.
// Reset (rst, synchronous, active high) disarms the decoder, empties both registers and
// restores timer_period to 10000 and bit_separator to 50.
module sensor_edge_interval_frame_decoder
  import sefd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CountWidth-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,   // [15:0] edge_count
  input  logic [1:0]             s_axis_tuser,   // [1:0] opcode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // [7:0] humidity, [15:8] temperature
  output logic [1:0]             m_axis_tuser    // [1:0] status
);

  logic [CountWidth-1:0] timer_period;
  logic [SepWidth-1:0]   bit_separator;

  logic                  in_valid;
  logic [1:0]            in_op;
  logic [CountWidth-1:0] in_count;

  logic                  armed, armed_next;
  logic [PosWidth-1:0]   bit_position, bit_position_next;
  logic [FrameLen-1:0]   frame_bits, frame_bits_next;
  logic [CountWidth-1:0] previous_count, previous_count_next;

  logic                  out_valid;
  status_t               out_status;
  logic [ByteWidth-1:0]  out_hum, out_temp;

  logic                  res_valid;
  status_t               res_status;
  logic [ByteWidth-1:0]  res_hum, res_temp;

  logic                  advance;
  logic [16:0]           interval;
  logic [17:0]           wrap_sum;
  logic                  interval_bad;
  logic [16:0]           s1, s2, s3, s4;
  logic                  low_bit, high_bit, start_win;
  logic [FrameLen-1:0]   shifted;
  logic [ByteWidth-1:0]  byte_sum;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Interval to the previous edge, wrapping modulo period plus one
  assign wrap_sum = {2'b00, timer_period} + {2'b00, in_count} + 18'd1
                  - {2'b00, previous_count};

  always_comb begin
    if (in_count >= previous_count) begin
      interval     = {1'b0, in_count} - {1'b0, previous_count};
      interval_bad = 1'b0;
    end else begin
      interval     = wrap_sum[16:0];
      interval_bad = wrap_sum[17];
    end
  end

  assign s1 = {3'b000, bit_separator};
  assign s2 = {2'b00, bit_separator, 1'b0};
  assign s3 = s1 + s2;
  assign s4 = {1'b0, bit_separator, 2'b00};

  assign low_bit   = !interval_bad && interval > s1 && interval < s2;
  assign high_bit  = !interval_bad && interval > s2 && interval < s3;
  assign start_win = !interval_bad && interval > s3 && interval < s4;

  assign shifted  = {frame_bits[FrameLen-2:0], high_bit};
  assign byte_sum = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];

  always_comb begin
    armed_next          = armed;
    bit_position_next   = bit_position;
    frame_bits_next     = frame_bits;
    previous_count_next = previous_count;
    res_valid           = 1'b0;
    res_status          = STATUS_OK;
    res_hum             = '0;
    res_temp            = '0;
    case (in_op)
      OP_START: begin
        armed_next        = 1'b1;
        bit_position_next = '0;
        frame_bits_next   = '0;
      end
      OP_TIMEOUT: begin
        if (armed) begin
          res_valid         = 1'b1;
          res_status        = STATUS_NO_CONN;
          armed_next        = 1'b0;
          bit_position_next = '0;
        end
      end
      OP_EDGE: begin
        if (armed) begin
          previous_count_next = in_count;
          if (start_win) begin
            bit_position_next = PosWidth'(1);
            frame_bits_next   = '0;
          end else if ((low_bit || high_bit) && bit_position != '0) begin
            frame_bits_next   = shifted;
            bit_position_next = bit_position + PosWidth'(1);
            if (bit_position == PosWidth'(FrameLen)) begin
              res_valid         = 1'b1;
              armed_next        = 1'b0;
              bit_position_next = '0;
              if (byte_sum != shifted[7:0]) begin
                res_status = STATUS_CHECK_ERR;
              end else begin
                res_status = STATUS_OK;
                res_hum    = shifted[39:32];
                res_temp   = shifted[23:16];
              end
            end
          end else if (bit_position != '0) begin
            res_valid         = 1'b1;
            res_status        = STATUS_PKT_ERR;
            armed_next        = 1'b0;
            bit_position_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period  <= PeriodReset;
      bit_separator <= SeparatorReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMER_PERIOD:  timer_period  <= cfg_data;
        REG_BIT_SEPARATOR: bit_separator <= cfg_data[SepWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op    <= s_axis_tuser;
      in_count <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      bit_position   <= '0;
      frame_bits     <= '0;
      previous_count <= '0;
    end else if (advance) begin
      armed          <= armed_next;
      bit_position   <= bit_position_next;
      frame_bits     <= frame_bits_next;
      previous_count <= previous_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_status <= res_status;
      out_hum    <= res_hum;
      out_temp   <= res_temp;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_temp, out_hum};
  assign m_axis_tuser  = out_status;

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    bit_position <= PosWidth'(FrameLen))
    else $error("bit position past frame length");

  a_idle_no_pos: assert property (@(posedge clk) disable iff (rst)
    !armed |-> bit_position == '0)
    else $error("bit position set while disarmed");

  a_result_disarms: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |=> !armed && bit_position == '0)
    else $error("result transaction did not disarm");

  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled with result register empty");

  a_ok_has_checksum: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && res_status == STATUS_OK |->
      byte_sum == shifted[7:0] && bit_position == PosWidth'(FrameLen))
    else $error("ok status without complete, consistent frame");

endmodule

>>> tb/tb.sv
// Testbench for the sensor edge interval frame decoder: predicts each result and checks it.
`timescale 1ns / 1ps

module tb;
  import sefd_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned SettleCycles = 5;

  typedef struct packed {
    status_t    status;
    logic [7:0] humidity;
    logic [7:0] temperature;
  } reading_t;

  typedef enum int unsigned {
    FAULT_BAD_GAP,
    FAULT_TIMEOUT,
    FAULT_RESTART,
    FAULT_REFRAME
  } fault_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CountWidth-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata = '0;  // [15:0] edge_count
  logic [1:0]             s_axis_tuser = '0;  // [1:0] opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;       // [7:0] humidity, [15:8] temperature
  logic [1:0]             m_axis_tuser;       // [1:0] status

  sensor_edge_interval_frame_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder mirror
  logic [15:0] cfg_period = PeriodReset;
  logic [13:0] cfg_sep = SeparatorReset;
  bit          dec_armed = 1'b0;
  int unsigned dec_pos = 0;
  logic [39:0] dec_frame = '0;
  logic [15:0] dec_last_edge = '0;
  reading_t    readings_due[$];

  int unsigned items_sent = 0;
  int unsigned readings_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  task automatic close_read(input reading_t r);
    readings_due.push_back(r);
    dec_armed = 1'b0;
    dec_pos   = 0;
  endtask

  task automatic decode_step(input logic [1:0] op, input logic [15:0] count);
    int unsigned gap_ticks;
    int unsigned s;
    bit          short_bit;
    bit          long_bit;
    logic [7:0]  sum;
    reading_t    r;
    s = 32'(cfg_sep);
    r = '{status: STATUS_OK, humidity: 8'd0, temperature: 8'd0};
    case (op)
      OP_START: begin
        dec_armed = 1'b1;
        dec_pos   = 0;
        dec_frame = '0;
      end
      OP_TIMEOUT: begin
        if (dec_armed) begin
          r.status = STATUS_NO_CONN;
          close_read(r);
        end
      end
      OP_EDGE: begin
        if (dec_armed) begin
          if (count >= dec_last_edge) gap_ticks = 32'(count) - 32'(dec_last_edge);
          else gap_ticks = 32'(cfg_period) - 32'(dec_last_edge) + 32'(count) + 1;
          dec_last_edge = count;
          short_bit = gap_ticks > s && gap_ticks < 2 * s;
          long_bit  = gap_ticks > 2 * s && gap_ticks < 3 * s;
          if (gap_ticks > 3 * s && gap_ticks < 4 * s) begin
            dec_pos   = 1;
            dec_frame = '0;
          end else if ((short_bit || long_bit) && dec_pos > 0) begin
            dec_frame = {dec_frame[38:0], long_bit};
            dec_pos++;
            if (dec_pos > FrameLen) begin
              sum = dec_frame[39:32] + dec_frame[31:24] + dec_frame[23:16] + dec_frame[15:8];
              if (sum != dec_frame[7:0]) begin
                r.status = STATUS_CHECK_ERR;
              end else begin
                r.humidity    = dec_frame[39:32];
                r.temperature = dec_frame[23:16];
              end
              close_read(r);
            end
          end else if (dec_pos > 0) begin
            r.status = STATUS_PKT_ERR;
            close_read(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch %s at %0t ns: got %0d, want %0d", what, $time, got, want);
  endtask

  // result checker
  reading_t head;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected result, status", int'(m_axis_tuser), -1);
      end else begin
        head = readings_due.pop_front();
        readings_checked++;
        if (head.status == STATUS_OK || head.status == STATUS_CHECK_ERR) frames_closed++;
        if (m_axis_tuser !== head.status)
          report_mismatch("status", int'(m_axis_tuser), int'(head.status));
        if (m_axis_tdata[7:0] !== head.humidity)
          report_mismatch("humidity", int'(m_axis_tdata[7:0]), int'(head.humidity));
        if (m_axis_tdata[15:8] !== head.temperature)
          report_mismatch("temperature", int'(m_axis_tdata[15:8]), int'(head.temperature));
      end
    end
  end

  // receiver backpressure
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  logic [4:0]  rx_phase = '0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 5'd1;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
      2:       m_axis_tready <= (rx_phase[1:0] == 2'd0);
      default: m_axis_tready <= (rx_phase > 5'd26);
    endcase
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] count);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= count;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_step(op, count);
    items_sent++;
    burst_left--;
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle();
    if (burst_left != 0) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIMER_PERIOD) cfg_period = value;
    else cfg_sep = value[13:0];
    reg_writes++;
  endtask

  function automatic int unsigned start_gap();
    return $urandom_range(3 * cfg_sep + 1, 4 * cfg_sep - 1);
  endfunction

  function automatic int unsigned bit_gap(input bit one);
    if (one) return $urandom_range(2 * cfg_sep + 1, 3 * cfg_sep - 1);
    return $urandom_range(cfg_sep + 1, 2 * cfg_sep - 1);
  endfunction

  // edge whose interval from the last armed edge is exactly ticks
  task automatic send_edge_after(input int unsigned ticks);
    int unsigned next;
    next = dec_last_edge + ticks;
    if (next > cfg_period) next -= cfg_period + 1;
    send_item(OP_EDGE, next[15:0]);
  endtask

  task automatic send_random_items(input int unsigned n);
    repeat (n) send_item(2'($urandom_range(0, 3)), 16'($urandom));
  endtask

  task automatic send_frame(input bit with_fault);
    logic [7:0]  hum, rel, temp, tfrac, chk;
    logic [39:0] word;
    int unsigned s, pos, fault_at, gap;
    fault_t      kind;
    bit          cut;
    s     = 32'(cfg_sep);
    hum   = 8'($urandom);
    rel   = 8'($urandom);
    temp  = 8'($urandom);
    tfrac = 8'($urandom);
    chk   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(hum + rel + temp + tfrac);
    word  = {hum, rel, temp, tfrac, chk};
    fault_at = with_fault ? $urandom_range(0, FrameLen - 1) : FrameLen;
    kind  = fault_t'($urandom_range(0, 3));
    cut   = 1'b0;
    send_item(OP_START, 16'($urandom));
    send_item(OP_EDGE, 16'($urandom_range(0, cfg_period)));  // sync, brings count in range
    send_edge_after(start_gap());
    for (pos = 0; pos < FrameLen && !cut; pos++) begin
      if (pos == fault_at) begin
        case (kind)
          FAULT_BAD_GAP: begin
            case ($urandom_range(0, 5))
              0:       gap = s;
              1:       gap = 2 * s;
              2:       gap = 3 * s;
              3:       gap = 4 * s;
              4:       gap = $urandom_range(0, s);
              default: gap = $urandom_range(4 * s, cfg_period);
            endcase
            send_edge_after(gap);
            cut = 1'b1;
          end
          FAULT_TIMEOUT: begin
            send_item(OP_TIMEOUT, 16'($urandom));
            cut = 1'b1;
          end
          FAULT_RESTART: begin
            send_item(OP_START, 16'($urandom));
            cut = 1'b1;
          end
          default: send_edge_after(start_gap());
        endcase
      end
      if (!cut) send_edge_after(bit_gap(word[FrameLen - 1 - pos]));
    end
  endtask

  task automatic test_directed_cases();
    send_item(OP_TIMEOUT, 16'd0);        // timeout while idle
    send_item(OP_EDGE, 16'd500);         // edge while idle
    send_item(OP_RESERVED, 16'hFFFF);
    send_item(OP_START, 16'h0000);
    send_item(OP_EDGE, 16'hFFFF);        // count above period
    send_item(OP_EDGE, 16'd100);         // wrap from out-of-range count
    send_item(OP_EDGE, 16'd275);         // frame start
    send_item(OP_EDGE, 16'd350);         // bit 0
    send_item(OP_EDGE, 16'd470);         // bit 1
    send_item(OP_TIMEOUT, 16'hFFFF);     // no connection mid frame
    send_item(OP_START, 16'hAAAA);
    send_item(OP_EDGE, 16'd9990);
    send_item(OP_EDGE, 16'd159);         // frame start across wrap
    send_item(OP_EDGE, 16'd259);         // exactly 2S: packet error
    send_item(OP_START, 16'h5555);
    send_item(OP_EDGE, 16'd0);
    send_item(OP_EDGE, 16'd200);         // exactly 4S before frame start
    send_item(OP_EDGE, 16'd351);         // frame start
    send_item(OP_START, 16'd0);          // restart while armed
    send_item(OP_EDGE, 16'd401);         // exactly S, no frame open
    send_item(OP_TIMEOUT, 16'd0);
    send_item(OP_TIMEOUT, 16'd0);
  endtask

  task automatic test_frame_traffic(input int unsigned n);
    int unsigned stop_at, pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame($urandom_range(0, 2) == 0);
      end else if (pick < 75) begin
        send_item(OP_START, 16'($urandom));
        send_item(OP_EDGE, 16'($urandom_range(0, cfg_period)));
        if ($urandom_range(0, 1) == 1) begin
          send_edge_after(start_gap());
          repeat ($urandom_range(0, 6)) send_edge_after(bit_gap(1'($urandom_range(0, 1))));
        end
        send_item(OP_TIMEOUT, 16'($urandom));
      end else begin
        send_random_items($urandom_range(1, 3));
      end
    end
  endtask

  task automatic test_degenerate_windows();
    write_reg(REG_TIMER_PERIOD, 16'd1);
    write_reg(REG_BIT_SEPARATOR, 16'hC000);  // separator reads as zero
    send_random_items(30);
    write_reg(REG_BIT_SEPARATOR, 16'd1);
    send_random_items(30);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_frame_traffic(200);

    write_reg(REG_TIMER_PERIOD, 16'hFFFF);
    write_reg(REG_BIT_SEPARATOR, 16'd16383);
    test_frame_traffic(150);

    write_reg(REG_TIMER_PERIOD, 16'd255);
    write_reg(REG_BIT_SEPARATOR, 16'd5);
    test_frame_traffic(150);

    write_reg(REG_TIMER_PERIOD, 16'd1000);
    write_reg(REG_BIT_SEPARATOR, 16'd2);
    test_frame_traffic(150);

    test_degenerate_windows();
    settle();

    $display("%0d input transactions, %0d results checked, %0d frames closed",
             items_sent, readings_checked, frames_closed);
    $display("%0d register writes, separators 0 to 16383, periods 1 to 65535", reg_writes);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
